@@ rtl/pmtp_pkg.sv @@
// pmtp_pkg: shared types and constants of the pmt section stream parser
// item structs for the input and result channels, parse phase encoding
// no dependencies
package pmtp_pkg;

    // input item: one section byte with its start flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       section_start;
    } t_in_item;

    // result item: one stream loop entry
    typedef struct packed {
        logic [7:0]  stream_type;
        logic [12:0] elementary_pid;
        logic [11:0] es_desc_len;
        logic [15:0] program_number;
        logic [12:0] pcr_pid;
        logic        last_entry;
        logic        overrun;
    } t_out_item;

    // parse phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_HEADER    = 6'b000010,
        PH_PROG_DESC = 6'b000100,
        PH_ENTRY     = 6'b001000,
        PH_ES_DESC   = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    // header byte positions that carry fields
    localparam logic [3:0] HDR_SLEN_HI = 4'd1;
    localparam logic [3:0] HDR_SLEN_LO = 4'd2;
    localparam logic [3:0] HDR_PNUM_HI = 4'd3;
    localparam logic [3:0] HDR_PNUM_LO = 4'd4;
    localparam logic [3:0] HDR_PCR_HI  = 4'd8;
    localparam logic [3:0] HDR_PCR_LO  = 4'd9;
    localparam logic [3:0] HDR_PIL_HI  = 4'd10;
    localparam logic [3:0] HDR_PIL_LO  = 4'd11;

    // entry header byte indexes
    localparam logic [2:0] ENT_TYPE    = 3'd0;
    localparam logic [2:0] ENT_PID_HI  = 3'd1;
    localparam logic [2:0] ENT_PID_LO  = 3'd2;
    localparam logic [2:0] ENT_INFO_HI = 3'd3;
    localparam logic [2:0] ENT_INFO_LO = 3'd4;

    // fixed byte counts of the section layout
    localparam logic [12:0] HDR_TAIL_BYTES  = 13'd13;
    localparam logic [12:0] ENT_HDR_BYTES   = 13'd5;

endpackage

@@ rtl/pmtp_parser.sv @@
// pmtp_parser: parse state of the pmt section and result formation
// updates state once per accepted byte, flags a result in the same cycle
// depends on pmtp_pkg
module pmtp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  pmtp_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output pmtp_pkg::t_out_item o_res
);

    pmtp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_byte_pos, n_byte_pos;
    logic [11:0] r_sec_len, n_sec_len;
    logic [15:0] r_prog_num, n_prog_num;
    logic [12:0] r_pcr_pid, n_pcr_pid;
    logic [3:0]  r_pil_hi, n_pil_hi;
    logic [2:0]  r_ent_idx, n_ent_idx;
    logic [7:0]  r_ent_type, n_ent_type;
    logic [12:0] r_ent_pid, n_ent_pid;
    logic [3:0]  r_ent_info_hi, n_ent_info_hi;
    logic [11:0] r_skip, n_skip;
    logic [12:0] r_loop, n_loop;

    logic [7:0]  w_b;
    logic [11:0] w_pil_full;
    logic [12:0] w_need;
    logic [11:0] w_skip_dec;
    logic [11:0] w_esl;
    logic [12:0] w_span;
    logic        w_last;
    logic        w_over;

    assign w_b        = i_item.data_byte;
    assign w_pil_full = {r_pil_hi, w_b};
    assign w_need     = {1'b0, w_pil_full} + pmtp_pkg::HDR_TAIL_BYTES;
    assign w_skip_dec = r_skip - 12'd1;
    assign w_esl      = {r_ent_info_hi, w_b};
    assign w_span     = {1'b0, w_esl} + pmtp_pkg::ENT_HDR_BYTES;
    assign w_last     = (r_loop <= w_span);
    assign w_over     = (r_loop < w_span);

    // next state for one accepted byte
    always_comb begin
        n_phase       = r_phase;
        n_byte_pos    = r_byte_pos;
        n_sec_len     = r_sec_len;
        n_prog_num    = r_prog_num;
        n_pcr_pid     = r_pcr_pid;
        n_pil_hi      = r_pil_hi;
        n_ent_idx     = r_ent_idx;
        n_ent_type    = r_ent_type;
        n_ent_pid     = r_ent_pid;
        n_ent_info_hi = r_ent_info_hi;
        n_skip        = r_skip;
        n_loop        = r_loop;
        o_res_valid   = 1'b0;

        if (i_item.section_start) begin
            n_byte_pos = 4'd1;
            n_sec_len  = '0;
            n_prog_num = '0;
            n_pcr_pid  = '0;
            n_pil_hi   = '0;
            n_phase    = pmtp_pkg::PH_HEADER;
        end else begin
            case (r_phase)
                pmtp_pkg::PH_HEADER: begin
                    case (r_byte_pos)
                        pmtp_pkg::HDR_SLEN_HI: n_sec_len  = {w_b[3:0], 8'd0};
                        pmtp_pkg::HDR_SLEN_LO: n_sec_len  = {r_sec_len[11:8], w_b};
                        pmtp_pkg::HDR_PNUM_HI: n_prog_num = {w_b, 8'd0};
                        pmtp_pkg::HDR_PNUM_LO: n_prog_num = {r_prog_num[15:8], w_b};
                        pmtp_pkg::HDR_PCR_HI:  n_pcr_pid  = {w_b[4:0], 8'd0};
                        pmtp_pkg::HDR_PCR_LO:  n_pcr_pid  = {r_pcr_pid[12:8], w_b};
                        pmtp_pkg::HDR_PIL_HI:  n_pil_hi   = w_b[3:0];
                        default: ;
                    endcase
                    if (r_byte_pos == pmtp_pkg::HDR_PIL_LO) begin
                        // loop length excludes header tail, descriptors and crc
                        n_loop = ({1'b0, r_sec_len} > w_need)
                               ? ({1'b0, r_sec_len} - w_need) : 13'd0;
                        n_skip = w_pil_full;
                        if (w_pil_full == 12'd0) begin
                            n_ent_idx = pmtp_pkg::ENT_TYPE;
                            n_phase   = (n_loop == 13'd0) ? pmtp_pkg::PH_DONE
                                                          : pmtp_pkg::PH_ENTRY;
                        end else begin
                            n_phase = pmtp_pkg::PH_PROG_DESC;
                        end
                    end else begin
                        n_byte_pos = r_byte_pos + 4'd1;
                    end
                end
                pmtp_pkg::PH_PROG_DESC, pmtp_pkg::PH_ES_DESC: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 12'd0) begin
                        n_ent_idx = pmtp_pkg::ENT_TYPE;
                        n_phase   = (r_loop == 13'd0) ? pmtp_pkg::PH_DONE
                                                      : pmtp_pkg::PH_ENTRY;
                    end
                end
                pmtp_pkg::PH_ENTRY: begin
                    case (r_ent_idx)
                        pmtp_pkg::ENT_TYPE:    n_ent_type    = w_b;
                        pmtp_pkg::ENT_PID_HI:  n_ent_pid     = {w_b[4:0], 8'd0};
                        pmtp_pkg::ENT_PID_LO:  n_ent_pid     = {r_ent_pid[12:8], w_b};
                        pmtp_pkg::ENT_INFO_HI: n_ent_info_hi = w_b[3:0];
                        default: ;
                    endcase
                    if (r_ent_idx != pmtp_pkg::ENT_INFO_LO) begin
                        n_ent_idx = r_ent_idx + 3'd1;
                    end else begin
                        // entry header complete: emit and move on
                        o_res_valid = 1'b1;
                        n_ent_idx   = pmtp_pkg::ENT_TYPE;
                        if (w_last) begin
                            n_loop  = '0;
                            n_phase = pmtp_pkg::PH_DONE;
                        end else begin
                            n_loop  = r_loop - w_span;
                            n_skip  = w_esl;
                            n_phase = (w_esl == 12'd0) ? pmtp_pkg::PH_ENTRY
                                                       : pmtp_pkg::PH_ES_DESC;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields
    always_comb begin
        o_res.stream_type    = r_ent_type;
        o_res.elementary_pid = r_ent_pid;
        o_res.es_desc_len    = w_esl;
        o_res.program_number = r_prog_num;
        o_res.pcr_pid        = r_pcr_pid;
        o_res.last_entry     = w_last;
        o_res.overrun        = w_over;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pmtp_pkg::PH_IDLE;
            r_byte_pos    <= '0;
            r_sec_len     <= '0;
            r_prog_num    <= '0;
            r_pcr_pid     <= '0;
            r_pil_hi      <= '0;
            r_ent_idx     <= '0;
            r_ent_type    <= '0;
            r_ent_pid     <= '0;
            r_ent_info_hi <= '0;
            r_skip        <= '0;
            r_loop        <= '0;
        end else if (i_item_valid) begin
            r_phase       <= n_phase;
            r_byte_pos    <= n_byte_pos;
            r_sec_len     <= n_sec_len;
            r_prog_num    <= n_prog_num;
            r_pcr_pid     <= n_pcr_pid;
            r_pil_hi      <= n_pil_hi;
            r_ent_idx     <= n_ent_idx;
            r_ent_type    <= n_ent_type;
            r_ent_pid     <= n_ent_pid;
            r_ent_info_hi <= n_ent_info_hi;
            r_skip        <= n_skip;
            r_loop        <= n_loop;
        end
    end

endmodule

@@ rtl/pmtp_out_fifo.sv @@
// pmtp_out_fifo: two-entry result buffer between parser and output channel
// ready comes from the registered fill count, with no combinational path from the output ready
// depends on pmtp_pkg
module pmtp_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    input  pmtp_pkg::t_out_item i_wr_data,
    output logic                o_wr_ready,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output pmtp_pkg::t_out_item o_rd_data
);

    pmtp_pkg::t_out_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/pmtp_section_stream_parser_top.sv @@
// pmt_section_stream_parser_top: pmt section byte parser with result buffer
// result path: the fifth entry byte flags a result, which is registered in the output buffer
// throughput: one byte per cycle while the result buffer has room
// the two-entry output buffer keeps input ready high until both entries hold waiting results
// reset: synchronous active low, returns to idle until the next section start
// depends on pmtp_pkg, pmtp_parser, pmtp_out_fifo
module pmt_section_stream_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pmtp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pmtp_pkg::t_out_item o_out_data
);

    logic                w_accept;
    logic                w_res_valid;
    pmtp_pkg::t_out_item w_res;
    logic                w_fifo_ready;

    // a byte is taken whenever the result buffer has room
    assign o_in_ready = w_fifo_ready;
    assign w_accept   = i_in_valid && w_fifo_ready;

    pmtp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_accept),
        .i_item       (i_in_data),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    pmtp_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_accept && w_res_valid),
        .i_wr_data  (w_res),
        .o_wr_ready (w_fifo_ready),
        .o_rd_valid (o_out_valid),
        .i_rd_ready (i_out_ready),
        .o_rd_data  (o_out_data)
    );

endmodule
